// ===== hdl/mfpp_pkg.sv =====
package mfpp_pkg;

    localparam int unsigned PatchMinLen = 165;
    localparam int unsigned PowerGroup  = 51;
    localparam int unsigned DemandGroup = 115;
    localparam int unsigned GroupLen    = 16;
    localparam logic [15:0] CrcPoly     = 16'hA001;
    localparam logic [15:0] CrcInit     = 16'hFFFF;
    localparam logic [31:0] QnanBits    = 32'h7FC0_0000;

    // configuration register indexes
    typedef enum logic {
        t_REG_TOTAL = 1'b0,
        t_REG_PHASE = 1'b1
    } t_reg_idx;

    // item kinds decided by the front end
    typedef enum logic [1:0] {
        t_K_PASS = 2'd0,
        t_K_WORD = 2'd1,
        t_K_CRCL = 2'd2,
        t_K_CRCH = 2'd3
    } t_kind;

    // back end states
    typedef enum logic [1:0] {
        t_B_IDLE = 2'd0,
        t_B_ADD  = 2'd1,
        t_B_EMIT = 2'd2
    } t_bstate;

    // classified entry between front and back
    typedef struct packed {
        t_kind       kind;
        logic        first;
        logic        last;
        logic        patched;
        logic        use_total;
        logic [31:0] word;
    } t_entry;

    // crc update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/meter_frame_power_patcher.sv =====
// path: a plain byte is registered in the queue and then in the output register; the fourth
// byte of a corrected float word releases four beats after the 3-stage adder and the ADD state
// throughput: one beat per cycle for plain bytes unless the output stalls; a float word holds the
// back end in ADD and EMIT; a 4-entry queue lets the front keep accepting while it is busy
// reset: synchronous active low; clears position, crc, queue and corrections
module meter_frame_power_patcher #(
    parameter int unsigned MAX_FRAME = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic [8:0]  i_frame_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_run_end,
    output logic        o_frame_end,
    output logic        o_patched,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import mfpp_pkg::*;

    logic [31:0] r_total, r_phase;
    t_entry      s_fe, s_qh;
    logic        s_push, s_pop, s_full;
    t_entry      r_q [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_phase <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                t_REG_TOTAL: r_total <= i_cfg_data;
                t_REG_PHASE: r_phase <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mfpp_front #(.MaxFrame(MAX_FRAME)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_frame_byte   (i_frame_byte),
        .i_frame_length (i_frame_length),
        .o_push         (s_push),
        .o_entry        (s_fe),
        .i_full         (s_full)
    );

    // queue between front and back
    assign s_full = (r_cnt == 3'd4);
    assign s_qh   = r_q[r_rp];
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_q[r_wp] <= s_fe;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (s_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, s_push} - {2'd0, s_pop};
        end
    end

    mfpp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_avail            (r_cnt != 3'd0),
        .i_entry            (s_qh),
        .o_pop              (s_pop),
        .i_total_correction (r_total),
        .i_phase_correction (r_phase),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_out_byte         (o_out_byte),
        .o_run_end          (o_run_end),
        .o_frame_end        (o_frame_end),
        .o_patched          (o_patched)
    );

endmodule

// ===== hdl/mfpp_fadd.sv =====
// single precision adder, round to nearest even, 3 register stages
module mfpp_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_sum
);
    import mfpp_pkg::*;

    // stage 1: unpack, order by magnitude, align
    logic        r1_special;
    logic [31:0] r1_special_val;
    logic        r1_sa, r1_sub;
    logic [7:0]  r1_ea;
    logic [26:0] r1_ma, r1_mb;

    logic [31:0] s_x, s_y;
    logic [7:0]  s_ex, s_ey, s_d;
    logic [23:0] s_mx, s_my;
    logic [49:0] s_sh;
    logic        s_sticky;
    logic        s_nan, s_infx, s_infy;
    logic [31:0] s_sv;

    always_comb begin
        if (i_a[30:0] >= i_b[30:0]) begin
            s_x = i_a;
            s_y = i_b;
        end else begin
            s_x = i_b;
            s_y = i_a;
        end
        s_ex = (s_x[30:23] == 8'd0) ? 8'd1 : s_x[30:23];
        s_ey = (s_y[30:23] == 8'd0) ? 8'd1 : s_y[30:23];
        s_mx = {(s_x[30:23] != 8'd0), s_x[22:0]};
        s_my = {(s_y[30:23] != 8'd0), s_y[22:0]};
        s_d  = s_ex - s_ey;
        s_sh = (s_d > 8'd26) ? 50'd0 : ({s_my, 26'd0} >> s_d);
        s_sticky = (s_d > 8'd26) ? (s_my != 24'd0) : (s_sh[23:0] != 24'd0);
        s_nan  = (i_a[30:23] == 8'hFF && i_a[22:0] != 23'd0)
              || (i_b[30:23] == 8'hFF && i_b[22:0] != 23'd0);
        s_infx = (i_a[30:23] == 8'hFF && i_a[22:0] == 23'd0);
        s_infy = (i_b[30:23] == 8'hFF && i_b[22:0] == 23'd0);
        if (s_nan || (s_infx && s_infy && (i_a[31] != i_b[31]))) begin
            s_sv = QnanBits;
        end else if (s_infx) begin
            s_sv = i_a;
        end else begin
            s_sv = i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_special     <= s_nan || s_infx || s_infy;
            r1_special_val <= s_sv;
            r1_sa          <= s_x[31];
            r1_sub         <= s_x[31] ^ s_y[31];
            r1_ea          <= s_ex;
            r1_ma          <= {s_mx, 3'd0};
            r1_mb          <= {s_sh[49:24], s_sticky};
        end
    end

    // stage 2: add or subtract
    logic        r2_special;
    logic [31:0] r2_special_val;
    logic        r2_sign;
    logic [7:0]  r2_e;
    logic [27:0] r2_m;
    logic        r2_sub;
    logic        r2_sa;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_special     <= r1_special;
            r2_special_val <= r1_special_val;
            r2_sign        <= r1_sa;
            r2_sa          <= r1_sa;
            r2_sub         <= r1_sub;
            r2_e           <= r1_ea;
            r2_m           <= r1_sub ? ({1'b0, r1_ma} - {1'b0, r1_mb})
                                     : ({1'b0, r1_ma} + {1'b0, r1_mb});
        end
    end

    // stage 3: normalize, round, pack
    logic [4:0]  s_lz;
    logic [9:0]  s_e;
    logic [27:0] s_n;
    logic [24:0] s_r;
    logic        s_g, s_st, s_up;
    logic [9:0]  s_ef;
    logic [31:0] s_res;

    always_comb begin
        s_lz = 5'd0;
        for (int i = 0; i < 28; i++) begin
            if (r2_m[i]) begin
                s_lz = 5'(27 - i);
            end
        end
        s_n = r2_m;
        s_e = {2'd0, r2_e};
        if (r2_m[27]) begin
            s_n = {1'b0, r2_m[27:2], r2_m[1] | r2_m[0]};
            s_e = s_e + 10'd1;
        end else if (s_lz > 5'd1) begin
            // shift left, limited so the exponent stays at least one
            if ({5'd0, s_lz - 5'd1} < s_e) begin
                s_n = r2_m << (s_lz - 5'd1);
                s_e = s_e - {5'd0, s_lz - 5'd1};
            end else begin
                s_n = r2_m << (s_e[4:0] - 5'd1);
                s_e = 10'd1;
            end
        end
        s_g  = s_n[2];
        s_st = s_n[1] | s_n[0];
        s_up = s_g && (s_st || s_n[3]);
        s_r  = {1'b0, s_n[26:3]} + {24'd0, s_up};
        s_ef = s_e;
        if (s_r[24]) begin
            s_r  = s_r >> 1;
            s_ef = s_ef + 10'd1;
        end
        if (s_r[23] == 1'b0) begin
            s_ef = 10'd0;
        end
        if (r2_m == 28'd0) begin
            s_res = {r2_sub ? 1'b0 : r2_sa, 31'd0};
        end else if (s_ef >= 10'd255) begin
            s_res = {r2_sign, 8'hFF, 23'd0};
        end else begin
            s_res = {r2_sign, s_ef[7:0], s_r[22:0]};
        end
        if (r2_special) begin
            s_res = r2_special_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sum <= s_res;
        end
    end

endmodule

// ===== hdl/mfpp_front.sv =====
// tracks frame position, holds word bytes, classifies each byte
module mfpp_front #(
    parameter int unsigned MaxFrame = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_frame_byte,
    input  logic [8:0]            i_frame_length,
    output logic                  o_push,
    output mfpp_pkg::t_entry      o_entry,
    input  logic                  i_full
);
    import mfpp_pkg::*;

    logic [7:0]  r_pos, n_pos;
    logic [8:0]  r_len, n_len;
    logic [23:0] r_held, n_held;

    logic [8:0]  s_len;
    logic [8:0]  s_p;
    logic        s_patched, s_last, s_in_word;
    logic [8:0]  s_off;
    logic        s_acc;

    assign o_ready = !i_full;
    assign s_acc   = i_valid && o_ready;

    always_comb begin
        s_len = r_len;
        if (r_pos == 8'd0) begin
            s_len = i_frame_length;
            if (s_len == 9'd0) begin
                s_len = 9'd1;
            end
            if (s_len > 9'(MaxFrame)) begin
                s_len = 9'(MaxFrame);
            end
        end
        s_p       = {1'b0, r_pos};
        s_patched = s_len >= 9'(PatchMinLen);
        s_last    = (s_p + 9'd1) >= s_len;
        s_off     = 9'd0;
        s_in_word = 1'b0;
        if (s_patched && s_p >= 9'(PowerGroup) && s_p < 9'(PowerGroup + GroupLen)) begin
            s_in_word = 1'b1;
            s_off     = s_p - 9'(PowerGroup);
        end else if (s_patched && s_p >= 9'(DemandGroup)
                     && s_p < 9'(DemandGroup + GroupLen)) begin
            s_in_word = 1'b1;
            s_off     = s_p - 9'(DemandGroup);
        end
        o_entry.first     = (r_pos == 8'd0);
        o_entry.last      = s_last;
        o_entry.patched   = s_patched;
        o_entry.use_total = (s_off < 9'd4);
        o_entry.word      = {(r_pos == 8'd0) ? 24'd0 : r_held, i_frame_byte};
        if (s_in_word) begin
            o_entry.kind = t_K_WORD;
        end else if (s_patched && s_p + 9'd2 == s_len) begin
            o_entry.kind = t_K_CRCL;
        end else if (s_patched && s_p + 9'd1 == s_len) begin
            o_entry.kind = t_K_CRCH;
        end else begin
            o_entry.kind = t_K_PASS;
        end
        o_push = s_acc && !(s_in_word && s_off[1:0] != 2'd3);
        n_pos  = r_pos;
        n_len  = r_len;
        n_held = r_held;
        if (s_acc) begin
            n_len  = s_len;
            n_pos  = s_last ? 8'd0 : r_pos + 8'd1;
            n_held = (s_in_word && s_off[1:0] != 2'd3) ? o_entry.word[23:0] : 24'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_held <= '0;
        end else begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_held <= n_held;
        end
    end

endmodule

// ===== hdl/mfpp_back.sv =====
// pops entries, runs the adder, emits bytes and keeps the crc
module mfpp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  mfpp_pkg::t_entry i_entry,
    output logic             o_pop,
    input  logic [31:0]      i_total_correction,
    input  logic [31:0]      i_phase_correction,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_run_end,
    output logic             o_frame_end,
    output logic             o_patched
);
    import mfpp_pkg::*;

    t_bstate     r_st, n_st;
    logic [1:0]  r_cnt, n_cnt;
    logic [15:0] r_crc, n_crc;
    logic [31:0] r_word, n_word;
    logic        r_ov, n_ov;
    logic [7:0]  r_ob, n_ob;
    logic        r_ore, n_ore, r_ofe, n_ofe, r_opa, n_opa;
    logic [31:0] s_sum;
    logic        s_free;
    logic [15:0] s_crc0;

    assign s_free = !r_ov || i_ready;

    mfpp_fadd u_fadd (
        .i_clk (i_clk),
        .i_en  (1'b1),
        .i_a   (i_entry.word),
        .i_b   (i_entry.use_total ? i_total_correction : i_phase_correction),
        .o_sum (s_sum)
    );

    // next state
    always_comb begin
        n_st  = r_st;
        n_cnt = r_cnt;
        case (r_st)
            t_B_IDLE: begin
                if (i_avail && s_free && i_entry.kind == t_K_WORD) begin
                    n_st  = t_B_ADD;
                    n_cnt = 2'd0;
                end
            end
            t_B_ADD: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_st  = t_B_EMIT;
                    n_cnt = 2'd0;
                end
            end
            t_B_EMIT: begin
                if (s_free) begin
                    n_cnt = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_st = t_B_IDLE;
                    end
                end
            end
            default: n_st = t_B_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_crc0 = i_entry.first ? CrcInit : r_crc;
        o_pop  = 1'b0;
        n_crc  = r_crc;
        n_word = r_word;
        n_ov   = r_ov && !i_ready;
        n_ob   = r_ob;
        n_ore  = r_ore;
        n_ofe  = r_ofe;
        n_opa  = r_opa;
        case (r_st)
            t_B_IDLE: begin
                if (i_avail && s_free) begin
                    if (i_entry.kind == t_K_WORD) begin
                        n_crc = s_crc0;
                    end else begin
                        o_pop = 1'b1;
                        n_ov  = 1'b1;
                        n_ore = 1'b1;
                        n_ofe = i_entry.last;
                        n_opa = i_entry.patched;
                        case (i_entry.kind)
                            t_K_CRCL: n_ob = s_crc0[7:0];
                            t_K_CRCH: n_ob = s_crc0[15:8];
                            default: begin
                                n_ob  = i_entry.word[7:0];
                                n_crc = crc_byte(s_crc0, i_entry.word[7:0]);
                            end
                        endcase
                        if (i_entry.kind == t_K_CRCL || i_entry.kind == t_K_CRCH) begin
                            n_crc = s_crc0;
                        end
                    end
                end
            end
            t_B_ADD: begin
                if (r_cnt == 2'd3) begin
                    o_pop  = 1'b1;
                    n_word = (s_sum[30:23] == 8'hFF && s_sum[22:0] != 23'd0)
                           ? QnanBits : s_sum;
                end
            end
            t_B_EMIT: begin
                if (s_free) begin
                    n_ov   = 1'b1;
                    n_ob   = r_word[31:24];
                    n_ore  = (r_cnt == 2'd3);
                    n_ofe  = 1'b0;
                    n_opa  = 1'b1;
                    n_crc  = crc_byte(r_crc, r_word[31:24]);
                    n_word = {r_word[23:0], 8'd0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= t_B_IDLE;
            r_cnt <= '0;
            r_crc <= CrcInit;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            r_crc <= n_crc;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_ob   <= n_ob;
        r_ore  <= n_ore;
        r_ofe  <= n_ofe;
        r_opa  <= n_opa;
    end

    assign o_valid     = r_ov;
    assign o_out_byte  = r_ob;
    assign o_run_end   = r_ore;
    assign o_frame_end = r_ofe;
    assign o_patched   = r_opa;

endmodule
